### design/tcad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell attribute decoder package
// Shared constants and types for the attribute decoder.
// ----------------------------------------------------------------------------
package tcad_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PeriodW = 16;

  localparam logic [6:0]  SetGfxCode    = 7'h17;
  localparam logic [6:0]  ClrGfxCode    = 7'h07;
  localparam logic [6:0]  SpaceCode     = 7'h20;
  localparam logic [7:0]  SpaceGlyph    = 8'h20;
  localparam logic [7:0]  MosaicBase    = 8'hA0;
  localparam logic [15:0] HalfPeriodRst = 16'd330;

  typedef enum logic {
    ActCell = 1'b0,
    ActTick = 1'b1
  } tcad_action_e;

  typedef struct packed {
    logic         row_start;
    tcad_action_e action;
    logic [7:0]   cell_byte;
  } tcad_item_t;

endpackage

### design/text_cell_attribute_decoder_core.sv
`timescale 1ns / 1ps
// Path: an accepted request is registered in in_q, then its decoded result in glyph_q and inv_q.
// Throughput: one request per cycle, cell or tick, while a held result is not stalled; ticks produce no result.
// Reset: graphics mode off, blink phase on, blink count 0, half period 330.
// ----------------------------------------------------------------------------
// Text cell attribute decoder core
// Decodes screen cell bytes into glyph codes and an inverse flag.
// ----------------------------------------------------------------------------
module text_cell_attribute_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // blink_half_period
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] cell_byte
  input  logic [1:0]  s_axis_tuser,    // [0] action, [1] row_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] glyph_code
  output logic [0:0]  m_axis_tuser     // [0] inverse
);

  logic [tcad_pkg::PeriodW-1:0] half_period_q;
  logic                         in_vld_q;
  tcad_pkg::tcad_item_t         in_q;
  logic                         out_vld_q;
  logic [7:0]                   glyph_q;
  logic                         inv_q;
  logic                         is_tick;
  logic                         advance;
  logic                         cell_en;
  logic                         tick_en;
  logic                         blink_phase;
  logic [7:0]                   glyph;
  logic                         inverse;

  assign is_tick       = (in_q.action == tcad_pkg::ActTick);
  assign advance       = in_vld_q & (is_tick | ~out_vld_q | m_axis_tready);
  assign cell_en       = advance & ~is_tick;
  assign tick_en       = advance & is_tick;
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= tcad_pkg::HalfPeriodRst;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.cell_byte <= s_axis_tdata;
      in_q.action    <= tcad_pkg::tcad_action_e'(s_axis_tuser[0]);
      in_q.row_start <= s_axis_tuser[1];
    end
  end

  tcad_blink_timer u_blink (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_en),
    .half_period_i (half_period_q),
    .phase_o       (blink_phase)
  );

  tcad_cell_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_en_i     (cell_en),
    .item_i        (in_q),
    .blink_phase_i (blink_phase),
    .glyph_o       (glyph),
    .inverse_o     (inverse)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cell_en) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_en) begin
      glyph_q <= glyph;
      inv_q   <= inverse;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = glyph_q;
  assign m_axis_tuser[0] = inv_q;

endmodule

### design/tcad_blink_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blink timer
// Counts ticks and toggles the blink phase every half period.
// ----------------------------------------------------------------------------
module tcad_blink_timer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic [tcad_pkg::PeriodW-1:0] half_period_i,
  output logic                         phase_o
);

  logic [tcad_pkg::PeriodW-1:0] count_q, count_d;
  logic                         phase_q, phase_d;
  logic [tcad_pkg::PeriodW:0]   count_inc;

  always_comb begin
    count_inc = {1'b0, count_q} + {{tcad_pkg::PeriodW{1'b0}}, 1'b1};
    count_d   = count_q;
    phase_d   = phase_q;
    if (tick_i) begin
      if (count_inc >= {1'b0, half_period_i}) begin
        count_d = '0;
        phase_d = ~phase_q;
      end else begin
        count_d = count_inc[tcad_pkg::PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= 1'b1;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

### design/tcad_cell_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell decoder
// Tracks the graphics serial attribute and maps a cell byte to a glyph and an inverse flag.
// ----------------------------------------------------------------------------
module tcad_cell_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cell_en_i,
  input  tcad_pkg::tcad_item_t      item_i,
  input  logic                      blink_phase_i,
  output logic [tcad_pkg::ByteW-1:0] glyph_o,
  output logic                      inverse_o
);

  logic       gfx_q, gfx_d;
  logic       gfx_cur;
  logic [6:0] low7;
  logic [7:0] text_glyph;
  logic [7:0] b;

  always_comb begin
    b          = item_i.cell_byte;
    low7       = b[6:0];
    gfx_cur    = gfx_q & ~item_i.row_start;
    text_glyph = (low7 < tcad_pkg::SpaceCode) ? tcad_pkg::SpaceGlyph : {1'b0, low7};
    gfx_d      = gfx_cur;
    inverse_o  = 1'b0;
    if (low7 == tcad_pkg::SetGfxCode) begin
      gfx_d   = 1'b1;
      glyph_o = tcad_pkg::SpaceGlyph;
    end else if (low7 == tcad_pkg::ClrGfxCode) begin
      gfx_d   = 1'b0;
      glyph_o = tcad_pkg::SpaceGlyph;
    end else if (gfx_cur) begin
      if (b[5]) begin
        glyph_o = tcad_pkg::MosaicBase + {2'b00, b[6], b[4:0]};
      end else begin
        glyph_o = text_glyph;
      end
    end else begin
      glyph_o   = text_glyph;
      inverse_o = b[7] & blink_phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfx_q <= 1'b0;
    end else if (cell_en_i) begin
      gfx_q <= gfx_d;
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell attribute decoder testbench
// Drives cell and tick requests through the stream port, predicts glyph codes
// and inverse flags from a local decoder model, and checks each result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainWait  = 4;
  localparam int PhaseItems = 320;

  typedef struct packed {
    logic [7:0] glyph;
    logic       inv;
  } cell_glyph_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] cell_byte
  logic [1:0]  s_axis_tuser;   // [0] action, [1] row_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] glyph_code
  logic [0:0]  m_axis_tuser;   // [0] inverse

  text_cell_attribute_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // decoder model state
  logic        gfx_mode;
  logic        phase_on;
  logic [15:0] tick_count;
  logic [15:0] half_period;

  cell_glyph_t pending_glyphs[$];

  int snd_idle_pct;
  int rcv_stall_pct;
  int cycle_cnt;
  int fail_cnt;
  int n_cells;
  int n_ticks;
  int n_checked;
  int n_settings;
  int n_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cell_glyph_t decode_cell(logic [7:0] b, logic row);
    cell_glyph_t g;
    logic [6:0]  low;
    low   = b[6:0];
    g.inv = 1'b0;
    if (row) gfx_mode = 1'b0;
    if (low == tcad_pkg::SetGfxCode) begin
      gfx_mode = 1'b1;
      g.glyph  = tcad_pkg::SpaceGlyph;
    end else if (low == tcad_pkg::ClrGfxCode) begin
      gfx_mode = 1'b0;
      g.glyph  = tcad_pkg::SpaceGlyph;
    end else if (gfx_mode && b[5]) begin
      g.glyph = tcad_pkg::MosaicBase + {2'b00, b[6], b[4:0]};
    end else begin
      g.glyph = (low < tcad_pkg::SpaceCode) ? tcad_pkg::SpaceGlyph : {1'b0, low};
      if (!gfx_mode) g.inv = b[7] & phase_on;
    end
    return g;
  endfunction

  function automatic void step_blink_timer();
    logic [16:0] nxt;
    nxt = {1'b0, tick_count} + 17'd1;
    if (nxt >= {1'b0, half_period}) begin
      tick_count = '0;
      phase_on   = ~phase_on;
    end else begin
      tick_count = nxt[15:0];
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_glyphs.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    cell_glyph_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_glyphs.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: glyph %02h inverse %0b", m_axis_tdata,
                   m_axis_tuser[0]);
      end else begin
        want = pending_glyphs.pop_front();
        n_checked++;
        if (m_axis_tdata !== want.glyph || m_axis_tuser[0] !== want.inv) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: glyph exp %02h got %02h, inverse exp %0b got %0b",
                     want.glyph, m_axis_tdata, want.inv, m_axis_tuser[0]);
        end
      end
    end
  end

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
  endtask

  task automatic send_item(input tcad_pkg::tcad_action_e act, input logic [7:0] b,
                           input logic row);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {row, act};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (act == tcad_pkg::ActTick) begin
      step_blink_timer();
      n_ticks++;
    end else begin
      pending_glyphs.push_back(decode_cell(b, row));
      n_cells++;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [15:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    half_period = v;
    n_settings++;
  endtask

  task automatic send_ticks(input int count);
    for (int k = 0; k < count; k++)
      send_item(tcad_pkg::ActTick, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_cells();
    send_item(tcad_pkg::ActCell, 8'h00, 1'b1);
    send_item(tcad_pkg::ActCell, 8'hFF, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h80, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h1F, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h41, 1'b0);
    send_item(tcad_pkg::ActCell, {1'b0, tcad_pkg::SetGfxCode}, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h20, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h7F, 1'b0);
    send_item(tcad_pkg::ActCell, 8'hB5, 1'b0);
    send_item(tcad_pkg::ActCell, 8'hC1, 1'b0);
    send_item(tcad_pkg::ActCell, 8'h05, 1'b0);
    send_item(tcad_pkg::ActTick, 8'hFF, 1'b1);
    send_item(tcad_pkg::ActCell, 8'h3A, 1'b0);
    send_item(tcad_pkg::ActCell, {1'b1, tcad_pkg::ClrGfxCode}, 1'b0);
    send_item(tcad_pkg::ActCell, 8'hE0, 1'b0);
    send_item(tcad_pkg::ActCell, {1'b1, tcad_pkg::SetGfxCode}, 1'b0);
    send_item(tcad_pkg::ActCell, 8'hFF, 1'b0);
    send_item(tcad_pkg::ActCell, 8'hE5, 1'b1);
    send_item(tcad_pkg::ActCell, {1'b0, tcad_pkg::SetGfxCode}, 1'b1);
    send_item(tcad_pkg::ActCell, 8'h60, 1'b0);
    send_item(tcad_pkg::ActCell, {1'b0, tcad_pkg::ClrGfxCode}, 1'b1);
    send_item(tcad_pkg::ActCell, 8'h9F, 1'b0);
  endtask

  task automatic test_reset_period();
    for (int k = 0; k < 12; k++) begin
      send_ticks(30);
      send_item(tcad_pkg::ActCell, 8'hC8, 1'b1);
    end
  endtask

  task automatic test_blink_extremes();
    write_period(16'd1);
    for (int k = 0; k < 6; k++) begin
      send_item(tcad_pkg::ActTick, 8'h00, 1'b0);
      send_item(tcad_pkg::ActCell, 8'hA1, 1'b0);
    end
    write_period(16'd0);
    for (int k = 0; k < 6; k++) begin
      send_item(tcad_pkg::ActTick, 8'hFF, 1'b1);
      send_item(tcad_pkg::ActCell, 8'hFE, 1'b1);
    end
    // long period, count climbs without toggling
    write_period(16'hFFFF);
    set_idling(0, 0);
    send_item(tcad_pkg::ActCell, 8'hC1, 1'b1);
    send_ticks(40);
    send_item(tcad_pkg::ActCell, 8'hC1, 1'b0);
    // shorten period below current count
    write_period(16'd5);
    send_item(tcad_pkg::ActCell, 8'hC2, 1'b0);
    send_ticks(1);
    send_item(tcad_pkg::ActCell, 8'hC2, 1'b0);
    send_ticks(5);
    send_item(tcad_pkg::ActCell, 8'hC2, 1'b0);
  endtask

  task automatic send_row();
    int         len;
    int         pick;
    logic [7:0] b;
    logic       noisy;
    len   = $urandom_range(1, 16);
    noisy = ($urandom_range(99) < 8);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      b    = 8'($urandom);
      if (pick < 10) begin
        send_item(tcad_pkg::ActTick, b, 1'($urandom));
      end else begin
        if (!noisy) begin
          if (pick < 22) b[6:0] = tcad_pkg::SetGfxCode;
          else if (pick < 27) b[6:0] = tcad_pkg::ClrGfxCode;
          else if (pick < 60) b[5] = 1'b1;
        end
        send_item(tcad_pkg::ActCell, b,
                  noisy ? 1'($urandom) : (k == 0 || $urandom_range(99) < 3));
      end
    end
  endtask

  task automatic test_random_rows(input logic [15:0] period, input int snd, input int rcv);
    int stop_at;
    write_period(period);
    set_idling(snd, rcv);
    stop_at = n_items + PhaseItems;
    while (n_items < stop_at) send_row();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cycle_cnt     = 0;
    fail_cnt      = 0;
    n_cells       = 0;
    n_ticks       = 0;
    n_checked     = 0;
    n_settings    = 1;
    n_items       = 0;
    gfx_mode      = 1'b0;
    phase_on      = 1'b1;
    tick_count    = '0;
    half_period   = tcad_pkg::HalfPeriodRst;
    set_idling(0, 0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cells();
    set_idling(46, 46);
    test_reset_period();
    test_blink_extremes();
    test_random_rows(16'd1, 0, 0);
    test_random_rows(16'd3, 46, 0);
    test_random_rows(16'($urandom_range(2, 9)), 0, 46);
    test_random_rows(16'd7, 12, 12);
    drain_results();

    if (pending_glyphs.size() != 0) fail_cnt++;
    $display("Sent %0d cells and %0d ticks over %0d blink period settings,",
             n_cells, n_ticks, n_settings);
    $display("checked %0d glyphs, %0d failures.", n_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/tcad_pkg.sv
design/tcad_blink_timer.sv
design/tcad_cell_decode.sv
design/text_cell_attribute_decoder_core.sv
test/tb.sv
